// File: design/wtip_pkg.sv
package wtip_pkg;

    // field widths fixed by the result format
    localparam int CFG_W     = 26;
    localparam int TOK_LEN_W = 26;
    localparam int LINE_W    = 32;
    localparam int OUT_VAL_W = 64;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LINES = 2'd1;

    localparam logic [CFG_W-1:0] MAX_TOKEN_RESET = CFG_W'(32'd32 << 20);

    // characters of interest
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        EV_TOKEN      = 2'd0,
        EV_EMPTY_LINE = 2'd1,
        EV_TOO_LONG   = 2'd2,
        EV_END        = 2'd3
    } t_event;

    typedef struct packed {
        t_event                 event_res;
        logic [TOK_LEN_W-1:0]   token_length;
        logic [LINE_W-1:0]      line_number;
        logic                   long_ok;
        logic [OUT_VAL_W-1:0]   long_value;
        logic                   ulong_ok;
        logic [OUT_VAL_W-1:0]   ulong_value;
        logic                   int_ok;
        logic                   uint_ok;
        logic                   last;
    } t_result;

endpackage

// File: design/wtip_in_if.sv
interface wtip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;
    logic       end_of_stream;

    modport source (output valid, output byte_req, output end_of_stream, input ready);
    modport sink   (input valid, input byte_req, input end_of_stream, output ready);
endinterface

// File: design/wtip_out_if.sv
interface wtip_out_if;
    logic                                     valid;
    logic                                     ready;
    wtip_pkg::t_event                         event_res;
    logic [wtip_pkg::TOK_LEN_W-1:0]           token_length;
    logic [wtip_pkg::LINE_W-1:0]              line_number;
    logic                                     long_ok;
    logic signed [wtip_pkg::OUT_VAL_W-1:0]    long_value;
    logic                                     ulong_ok;
    logic [wtip_pkg::OUT_VAL_W-1:0]           ulong_value;
    logic                                     int_ok;
    logic                                     uint_ok;
    logic                                     last;

    modport source (
        output valid, output event_res, output token_length, output line_number,
        output long_ok, output long_value, output ulong_ok, output ulong_value,
        output int_ok, output uint_ok, output last,
        input ready
    );
    modport sink (
        input valid, input event_res, input token_length, input line_number,
        input long_ok, input long_value, input ulong_ok, input ulong_value,
        input int_ok, input uint_ok, input last,
        output ready
    );
endinterface

// File: design/whitespace_tokenizer_int_parse.sv
// Whitespace tokenizer with decimal integer parsing. One byte (or an
// end-of-stream mark) is taken per cycle while the result queue has room; the
// tokenizer state and the multiply-by-ten accumulator update in the cycle of
// acceptance, and the results of that item are written into a four-entry
// result queue that feeds the output. An item gives zero, one or two results;
// an item with two results (a token closed by end of stream or by a newline
// with line reporting on) takes two queue slots, so the sustained rate is one
// item per cycle as long as the results per item average one or less and the
// receiver does not stall. Input is held off while fewer than two queue slots
// are free. After a too-long token the block keeps taking items and drops them
// until reset. No clearing pass is needed after reset.
module whitespace_tokenizer_int_parse #(
    parameter int VALUE_BITS  = 64,
    parameter int LENGTH_BITS = 26
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wtip_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wtip_pkg::CFG_W-1:0]        i_cfg_data,
    wtip_in_if.sink                           i_in,
    wtip_out_if.source                        o_out
);

    localparam int PW     = VALUE_BITS + 4;
    localparam int LIM_W  = (LENGTH_BITS > wtip_pkg::CFG_W) ? LENGTH_BITS : wtip_pkg::CFG_W;
    localparam int DEPTH  = 4;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // configuration
    logic [wtip_pkg::CFG_W-1:0] r_max_tok;
    logic                       r_report;

    // tokenizer state
    logic                       r_in_tok, n_in_tok;
    logic [LENGTH_BITS-1:0]     r_cnt, n_cnt;
    logic [wtip_pkg::LINE_W-1:0] r_line, n_line;
    logic [VALUE_BITS-1:0]      r_mag, n_mag;
    logic                       r_neg, n_neg;
    logic                       r_digit, n_digit;
    logic                       r_bad, n_bad;
    logic                       r_ovf, n_ovf;
    logic                       r_err, n_err;

    // result queue
    wtip_pkg::t_result          r_fifo [DEPTH];
    logic [PTR_W-1:0]           r_wp, r_rp;
    logic [CNT_W-1:0]           r_count;

    logic                       acc, pop;
    logic [1:0]                 n_push;
    wtip_pkg::t_result          res_a, res_b, tok_res, second;
    logic                       emit_tok, emit_second;

    logic [7:0]                 ch;
    logic                       is_ws, is_digit, is_sign;
    logic [LENGTH_BITS-1:0]     cur_cnt;
    logic [VALUE_BITS-1:0]      cur_mag;
    logic                       cur_ovf;
    logic [PW-1:0]              prod;
    logic [LIM_W-1:0]           lim_cfg, lim_len, limit;
    logic [wtip_pkg::OUT_VAL_W-1:0] mag64;
    logic                       valid_num, lok, uok, min_neg;

    assign acc = i_in.valid && i_in.ready;
    assign pop = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count <= CNT_W'(DEPTH - 2));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tok <= wtip_pkg::MAX_TOKEN_RESET;
            r_report  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wtip_pkg::CFG_MAX_TOKEN:    r_max_tok <= i_cfg_data;
                wtip_pkg::CFG_REPORT_LINES: r_report  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // token parse results from the current state
    always_comb begin
        mag64     = wtip_pkg::OUT_VAL_W'(r_mag);
        valid_num = r_digit && !r_bad && !r_ovf;
        min_neg   = (r_mag == {1'b1, {(VALUE_BITS-1){1'b0}}});
        lok       = valid_num && (r_neg ? (!r_mag[VALUE_BITS-1] || min_neg)
                                        : !r_mag[VALUE_BITS-1]);
        uok       = valid_num && !r_neg;

        tok_res              = '0;
        tok_res.event_res    = wtip_pkg::EV_TOKEN;
        tok_res.token_length = wtip_pkg::TOK_LEN_W'(LIM_W'(r_cnt));
        tok_res.line_number  = r_line;
        tok_res.long_ok      = lok;
        tok_res.long_value   = lok ? (r_neg ? (64'd0 - mag64) : mag64) : '0;
        tok_res.ulong_ok     = uok;
        tok_res.ulong_value  = uok ? mag64 : '0;
        tok_res.int_ok       = lok && (r_neg ? (mag64 <= 64'h0000_0000_8000_0000)
                                             : (mag64 <= 64'h0000_0000_7FFF_FFFF));
        tok_res.uint_ok      = uok && (mag64 <= 64'h0000_0000_FFFF_FFFF);
        tok_res.last         = 1'b0;
    end

    // per-item state update and result selection
    always_comb begin
        ch       = i_in.byte_req;
        is_ws    = (ch == wtip_pkg::CH_SPACE) || (ch == wtip_pkg::CH_TAB) ||
                   (ch == wtip_pkg::CH_CR) || (ch == wtip_pkg::CH_LF);
        is_digit = (ch >= wtip_pkg::CH_ZERO) && (ch <= wtip_pkg::CH_NINE);
        is_sign  = (ch == wtip_pkg::CH_PLUS) || (ch == wtip_pkg::CH_MINUS);

        // a new token starts from cleared fields
        cur_cnt = r_in_tok ? r_cnt : '0;
        cur_mag = r_in_tok ? r_mag : '0;
        cur_ovf = r_in_tok && r_ovf;

        prod = PW'({cur_mag, 3'b000}) + PW'({cur_mag, 1'b0}) + PW'(ch[3:0]);

        lim_cfg = LIM_W'(r_max_tok);
        lim_len = LIM_W'({LENGTH_BITS{1'b1}});
        limit   = (lim_cfg < lim_len) ? lim_cfg : lim_len;

        n_in_tok = r_in_tok;
        n_cnt    = r_cnt;
        n_line   = r_line;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_digit  = r_digit;
        n_bad    = r_bad;
        n_ovf    = r_ovf;
        n_err    = r_err;

        emit_tok    = 1'b0;
        emit_second = 1'b0;
        second      = '0;
        second.line_number = r_line;

        if (acc && !r_err) begin
            if (i_in.end_of_stream) begin
                emit_tok         = r_in_tok;
                n_in_tok         = 1'b0;
                emit_second      = 1'b1;
                second.event_res = wtip_pkg::EV_END;
            end else if (is_ws) begin
                emit_tok = r_in_tok;
                n_in_tok = 1'b0;
                if (ch == wtip_pkg::CH_LF) begin
                    if (r_line != '1) begin
                        n_line = r_line + 1'b1;
                    end
                    if (r_report) begin
                        emit_second        = 1'b1;
                        second.event_res   = wtip_pkg::EV_EMPTY_LINE;
                        second.line_number = n_line;
                    end
                end
            end else begin
                n_in_tok = 1'b1;
                n_cnt    = cur_cnt;
                n_mag    = cur_mag;
                n_neg    = r_in_tok && r_neg;
                n_digit  = r_in_tok && r_digit;
                n_bad    = r_in_tok && r_bad;
                n_ovf    = cur_ovf;
                if (LIM_W'(cur_cnt) >= limit) begin
                    n_err            = 1'b1;
                    n_in_tok         = 1'b0;
                    emit_second      = 1'b1;
                    second.event_res = wtip_pkg::EV_TOO_LONG;
                end else begin
                    priority if ((cur_cnt == '0) && is_sign) begin
                        n_neg = (ch == wtip_pkg::CH_MINUS);
                    end else if (is_digit) begin
                        n_digit = 1'b1;
                        if (!cur_ovf) begin
                            if (|prod[PW-1:VALUE_BITS]) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_mag = prod[VALUE_BITS-1:0];
                            end
                        end
                    end else begin
                        n_bad = 1'b1;
                    end
                    n_cnt = cur_cnt + 1'b1;
                end
            end
        end

        // order results and mark the final one
        second.last = 1'b1;
        res_b       = second;
        if (emit_tok) begin
            res_a      = tok_res;
            res_a.last = !emit_second;
            n_push     = emit_second ? 2'd2 : 2'd1;
        end else begin
            res_a  = second;
            n_push = emit_second ? 2'd1 : 2'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tok <= 1'b0;
            r_cnt    <= '0;
            r_line   <= wtip_pkg::LINE_W'(1);
            r_mag    <= '0;
            r_neg    <= 1'b0;
            r_digit  <= 1'b0;
            r_bad    <= 1'b0;
            r_ovf    <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_in_tok <= n_in_tok;
            r_cnt    <= n_cnt;
            r_line   <= n_line;
            r_mag    <= n_mag;
            r_neg    <= n_neg;
            r_digit  <= n_digit;
            r_bad    <= n_bad;
            r_ovf    <= n_ovf;
            r_err    <= n_err;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(n_push);
            r_rp    <= r_rp + PTR_W'(pop);
            r_count <= r_count + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wp] <= res_a;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wp + PTR_W'(1)] <= res_b;
        end
    end

    // output side
    assign o_out.valid        = (r_count != '0);
    assign o_out.event_res    = r_fifo[r_rp].event_res;
    assign o_out.token_length = r_fifo[r_rp].token_length;
    assign o_out.line_number  = r_fifo[r_rp].line_number;
    assign o_out.long_ok      = r_fifo[r_rp].long_ok;
    assign o_out.long_value   = r_fifo[r_rp].long_value;
    assign o_out.ulong_ok     = r_fifo[r_rp].ulong_ok;
    assign o_out.ulong_value  = r_fifo[r_rp].ulong_value;
    assign o_out.int_ok       = r_fifo[r_rp].int_ok;
    assign o_out.uint_ok      = r_fifo[r_rp].uint_ok;
    assign o_out.last         = r_fifo[r_rp].last;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue count beyond depth");

    // an item is only taken with room for two results
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> (r_count <= CNT_W'(DEPTH - 2)))
        else $error("item accepted without queue room");

    // nothing is produced once the sticky error is set
    a_stuck_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (n_push == 2'd0))
        else $error("result produced after too-long error");

    // a newline advances the line count until saturation
    a_line_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !r_err && !i_in.end_of_stream && (i_in.byte_req == wtip_pkg::CH_LF) &&
         (r_line != '1)) |=> (r_line == $past(r_line) + 1'b1))
        else $error("line count did not advance on newline");

    // the sticky error stays until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("sticky error cleared without reset");

endmodule

// File: tb/tb_whitespace_tokenizer_int_parse.sv
module tb_whitespace_tokenizer_int_parse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [63:0] UMAX        = '1;

    // one row of the directed table: an item or a register write
    typedef struct {
        bit                                is_cfg;
        logic [wtip_pkg::CFG_IDX_W-1:0]    idx;
        logic [25:0]                       data;
        logic [7:0]                        ch;
        bit                                eos;
        bit                                typed;
        wtip_pkg::t_result                 want;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [wtip_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [wtip_pkg::CFG_W-1:0]     i_cfg_data;

    wtip_in_if  in_ch ();
    wtip_out_if out_ch ();

    whitespace_tokenizer_int_parse uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // tokenizer state mirrored by the predictor
    bit          in_tok   = 1'b0;
    logic [25:0] tok_cnt  = '0;
    logic [31:0] line_cnt = 32'd1;
    logic [63:0] mag      = '0;
    bit          neg      = 1'b0;
    bit          dig      = 1'b0;
    bit          bad      = 1'b0;
    bit          ovf      = 1'b0;
    bit          stuck    = 1'b0;
    logic [25:0] lim      = wtip_pkg::MAX_TOKEN_RESET;
    bit          rep      = 1'b0;

    wtip_pkg::t_result due_events[$];
    wtip_pkg::t_result head;

    int  fails       = 0;
    int  items_taken = 0;
    int  reg_writes  = 0;
    int  cycles      = 0;
    int  ev_seen[4]  = '{0, 0, 0, 0};
    bit  calm        = 1'b0;
    bit  hold_req    = 1'b0;

    function automatic bit is_blank(logic [7:0] b);
        return b == wtip_pkg::CH_SPACE || b == wtip_pkg::CH_TAB ||
               b == wtip_pkg::CH_CR || b == wtip_pkg::CH_LF;
    endfunction

    function automatic logic [7:0] any_mark();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_blank(b));
        return b;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic wtip_pkg::t_result res(wtip_pkg::t_event ev, logic [25:0] len,
                                              logic [31:0] line, bit lok, logic [63:0] lval,
                                              bit uok, logic [63:0] uval, bit iok, bit uiok);
        wtip_pkg::t_result r;
        r = '0;
        r.event_res    = ev;
        r.token_length = len;
        r.line_number  = line;
        r.long_ok      = lok;
        r.long_value   = lval;
        r.ulong_ok     = uok;
        r.ulong_value  = uval;
        r.int_ok       = iok;
        r.uint_ok      = uiok;
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic void add_event(wtip_pkg::t_event ev);
        wtip_pkg::t_result r;
        r = '0;
        r.event_res   = ev;
        r.line_number = line_cnt;
        due_events.push_back(r);
    endfunction

    // finished token: length, line and both parses
    function automatic void close_token();
        wtip_pkg::t_result r;
        bit                valid, lok, uok;
        valid = dig && !bad && !ovf;
        lok   = valid && (neg ? mag <= 64'h8000_0000_0000_0000 : mag <= 64'h7FFF_FFFF_FFFF_FFFF);
        uok   = valid && !neg;
        r = '0;
        r.event_res    = wtip_pkg::EV_TOKEN;
        r.token_length = tok_cnt;
        r.line_number  = line_cnt;
        r.long_ok      = lok;
        r.long_value   = lok ? (neg ? -mag : mag) : '0;
        r.ulong_ok     = uok;
        r.ulong_value  = uok ? mag : '0;
        r.int_ok       = lok && (neg ? mag <= 64'h8000_0000 : mag <= 64'h7FFF_FFFF);
        r.uint_ok      = uok && mag <= 64'hFFFF_FFFF;
        due_events.push_back(r);
        in_tok = 1'b0;
    endfunction

    // advance the tokenizer by one item, returns the number of results it made
    function automatic int scan_item(logic [7:0] ch, bit eos);
        int          n0;
        logic [63:0] d;
        n0 = due_events.size();
        if (!stuck) begin
            if (eos) begin
                if (in_tok) close_token();
                add_event(wtip_pkg::EV_END);
            end else if (is_blank(ch)) begin
                if (in_tok) close_token();
                if (ch == wtip_pkg::CH_LF) begin
                    if (line_cnt != '1) line_cnt++;
                    if (rep) add_event(wtip_pkg::EV_EMPTY_LINE);
                end
            end else begin
                if (!in_tok) begin
                    in_tok  = 1'b1;
                    tok_cnt = '0;
                    mag     = '0;
                    neg     = 1'b0;
                    dig     = 1'b0;
                    bad     = 1'b0;
                    ovf     = 1'b0;
                end
                if (tok_cnt >= lim) begin
                    stuck  = 1'b1;
                    in_tok = 1'b0;
                    add_event(wtip_pkg::EV_TOO_LONG);
                end else begin
                    if (tok_cnt == 0 &&
                        (ch == wtip_pkg::CH_PLUS || ch == wtip_pkg::CH_MINUS)) begin
                        neg = (ch == wtip_pkg::CH_MINUS);
                    end else if (ch >= wtip_pkg::CH_ZERO && ch <= wtip_pkg::CH_NINE) begin
                        d   = 64'(ch - wtip_pkg::CH_ZERO);
                        dig = 1'b1;
                        if (!ovf) begin
                            if (mag > (UMAX - d) / 10) ovf = 1'b1;
                            else mag = mag * 10 + d;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                    tok_cnt++;
                end
            end
        end
        if (due_events.size() > n0) due_events[due_events.size() - 1].last = 1'b1;
        return due_events.size() - n0;
    endfunction

    // offer one item, wait for acceptance, then predict its results
    task automatic push_item(input logic [7:0] ch, input bit eos, input bit typed,
                             input wtip_pkg::t_result want);
        int gap, made;
        bit live;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.byte_req      <= ch;
        in_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        live = !stuck;
        made = scan_item(ch, eos);
        if (live) items_taken++;
        if (typed) begin
            repeat (made) void'(due_events.pop_back());
            due_events.push_back(want);
        end
    endtask

    task automatic write_reg(input logic [wtip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [25:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == wtip_pkg::CFG_MAX_TOKEN) lim = val;
        else if (idx == wtip_pkg::CFG_REPORT_LINES) rep = val[0];
        reg_writes++;
    endtask

    // stop offering, wait for all results, then let the pipeline settle
    task automatic quiesce(input int settle);
        int k;
        k = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (due_events.size() != 0 && k < 5000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // one token, mostly a decimal near some boundary, sometimes garbage
    task automatic emit_token(input int maxlen);
        logic [7:0]  tok[$];
        logic [63:0] v;
        string       big;
        int          pick, s, n;
        big = "18446744073709551616";
        if ($urandom_range(0, 99) < 75) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: v = 64'($urandom_range(0, 9));
                1: v = 64'h7FFF_FFFE + 64'($urandom_range(0, 3));
                2: v = 64'hFFFF_FFFE + 64'($urandom_range(0, 2));
                3: v = 64'h7FFF_FFFF_FFFF_FFFE + 64'($urandom_range(0, 3));
                4: v = UMAX - 64'($urandom_range(0, 2));
                5: v = {$urandom, $urandom};
                6: v = 64'($urandom);
                default: v = 64'($urandom_range(0, 99999));
            endcase
            if ($urandom_range(0, 19) == 0) begin
                for (int i = 0; i < big.len(); i++) tok.push_back(big[i]);
            end else if (v == 0) begin
                tok.push_back(wtip_pkg::CH_ZERO);
            end else begin
                while (v != 0) begin
                    tok.push_front(8'(wtip_pkg::CH_ZERO + v % 10));
                    v = v / 10;
                end
            end
            // extra digit pushes large values past the 64-bit range
            if ($urandom_range(0, 9) == 0)
                tok.push_back(8'(wtip_pkg::CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) tok.push_front(wtip_pkg::CH_ZERO);
            s = $urandom_range(0, 9);
            if (maxlen <= 64 && $urandom_range(0, 19) == 0)
                while (tok.size() + (s < 4 ? 0 : 1) < maxlen)
                    tok.push_front(wtip_pkg::CH_ZERO);
            if ($urandom_range(0, 29) == 0) tok.delete();
            if (s >= 4 || tok.size() == 0)
                tok.push_front(s < 7 ? wtip_pkg::CH_MINUS : wtip_pkg::CH_PLUS);
            if ($urandom_range(0, 9) == 0)
                tok.insert($urandom_range(0, tok.size()), any_mark());
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) tok.push_back(any_mark());
        end
        while (tok.size() > maxlen) void'(tok.pop_back());
        foreach (tok[i]) push_item(tok[i], 1'b0, 1'b0, '0);
    endtask

    task automatic emit_separator();
        logic [7:0] pool[5];
        pool = '{wtip_pkg::CH_SPACE, wtip_pkg::CH_TAB, wtip_pkg::CH_CR,
                 wtip_pkg::CH_LF, wtip_pkg::CH_LF};
        if ($urandom_range(0, 99) < 6) begin
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 3)) push_item(pool[$urandom_range(0, 4)], 1'b0, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic [25:0] limit, input bit lines, input int maxlen,
                             input int count, input bit quiet, input bit press);
        int goal;
        quiesce(8);
        write_reg(wtip_pkg::CFG_MAX_TOKEN, limit);
        write_reg(wtip_pkg::CFG_REPORT_LINES, {25'($urandom), lines});
        calm = quiet;
        if (press) hold_req = 1'b1;
        goal = items_taken + count;
        while (items_taken < goal) begin
            emit_token(maxlen);
            emit_separator();
        end
        calm = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (due_events.size() == 0) begin
                $error("unexpected result: event %0d, line %0d",
                       out_ch.event_res, out_ch.line_number);
                fails++;
            end else begin
                head = due_events.pop_front();
                check_field("event_res", head.event_res, out_ch.event_res);
                check_field("token_length", head.token_length, out_ch.token_length);
                check_field("line_number", head.line_number, out_ch.line_number);
                check_field("long_ok", head.long_ok, out_ch.long_ok);
                check_field("long_value", head.long_value, out_ch.long_value);
                check_field("ulong_ok", head.ulong_ok, out_ch.ulong_ok);
                check_field("ulong_value", head.ulong_value, out_ch.ulong_value);
                check_field("int_ok", head.int_ok, out_ch.int_ok);
                check_field("uint_ok", head.uint_ok, out_ch.uint_ok);
                check_field("last", head.last, out_ch.last);
                ev_seen[head.event_res]++;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 400;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                out_ch.ready <= 1'b0;
                stall = pick_gap();
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     due_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_step plan[$];
        t_step s;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.byte_req      = '0;
        in_ch.end_of_stream = 1'b0;

        // directed rows; typed expectations where the result is obvious
        s = '{is_cfg: 1'b0, idx: '0, data: '0, ch: '0, eos: 1'b1, typed: 1'b1,
              want: res(wtip_pkg::EV_END, 0, 1, 0, 0, 0, 0, 0, 0)};
        plan.push_back(s);
        s.eos = 1'b0; s.typed = 1'b0; s.want = '0;
        s.ch = "7"; plan.push_back(s);
        s.ch = wtip_pkg::CH_SPACE; s.typed = 1'b1;
        s.want = res(wtip_pkg::EV_TOKEN, 1, 1, 1, 64'd7, 1, 64'd7, 1, 1); plan.push_back(s);
        s.typed = 1'b0;
        s.ch = wtip_pkg::CH_MINUS; plan.push_back(s);
        s.ch = "5"; plan.push_back(s);
        s.ch = wtip_pkg::CH_TAB; s.typed = 1'b1;
        s.want = res(wtip_pkg::EV_TOKEN, 2, 1, 1, -64'sd5, 0, 0, 1, 0); plan.push_back(s);
        s.typed = 1'b0;
        s.ch = wtip_pkg::CH_PLUS; plan.push_back(s);
        // sign alone is not a number
        s.ch = wtip_pkg::CH_CR; s.typed = 1'b1;
        s.want = res(wtip_pkg::EV_TOKEN, 1, 1, 0, 0, 0, 0, 0, 0); plan.push_back(s);
        s.typed = 1'b0;
        s.ch = 8'h00; plan.push_back(s);
        // token closed by LF keeps the old line
        s.ch = wtip_pkg::CH_LF; s.typed = 1'b1;
        s.want = res(wtip_pkg::EV_TOKEN, 1, 1, 0, 0, 0, 0, 0, 0); plan.push_back(s);
        s.typed = 1'b0;
        s.ch = 8'hFF; plan.push_back(s);
        s.ch = 8'h5A; s.eos = 1'b1; plan.push_back(s);
        s.eos = 1'b0;
        s.is_cfg = 1'b1; s.idx = wtip_pkg::CFG_REPORT_LINES; s.data = 26'd1; plan.push_back(s);
        s.is_cfg = 1'b0;
        s.ch = wtip_pkg::CH_LF; s.typed = 1'b1;
        s.want = res(wtip_pkg::EV_EMPTY_LINE, 0, 3, 0, 0, 0, 0, 0, 0); plan.push_back(s);
        s.typed = 1'b0;
        s.ch = "1"; plan.push_back(s);
        s.ch = "2"; plan.push_back(s);
        s.ch = wtip_pkg::CH_LF; plan.push_back(s);
        s.ch = wtip_pkg::CH_MINUS; plan.push_back(s);
        plan.push_back(s);
        s.ch = wtip_pkg::CH_SPACE; plan.push_back(s);
        s.ch = 8'h0B; plan.push_back(s);
        s.ch = "9"; plan.push_back(s);
        s.ch = 8'h00; s.eos = 1'b1; plan.push_back(s);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                quiesce(8);
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                push_item(plan[i].ch, plan[i].eos, plan[i].typed, plan[i].want);
            end
        end

        // random phases over several limit and line-reporting settings
        run_phase(26'h200_0000, 1'b1, 40, 450, 1'b0, 1'b0);
        run_phase(26'h3FF_FFFF, 1'b0, 40, 400, 1'b0, 1'b1);
        run_phase(26'd24, 1'b1, 24, 400, 1'b0, 1'b0);
        run_phase(26'd1, 1'($urandom), 1, 300, 1'b0, 1'b0);
        run_phase(26'($urandom_range(25, 300)), 1'b0, 22, 200, 1'b1, 1'b0);

        // tiny limit: drive into the sticky too-long error, then check silence
        quiesce(8);
        write_reg(wtip_pkg::CFG_MAX_TOKEN, 26'($urandom_range(0, 2)));
        write_reg(wtip_pkg::CFG_REPORT_LINES, 26'd1);
        while (!stuck) begin
            emit_token(int'(lim) + 3);
            emit_separator();
        end
        repeat (30) push_item(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);

        quiesce(20);
        if (due_events.size() != 0) begin
            $error("%0d expected results never arrived", due_events.size());
            fails++;
        end
        $display("%0d items taken, %0d register writes; results: %0d tokens, %0d empty lines,",
                 items_taken, reg_writes, ev_seen[wtip_pkg::EV_TOKEN],
                 ev_seen[wtip_pkg::EV_EMPTY_LINE]);
        $display("%0d too-long, %0d end-of-stream; %0d mismatches in %0d cycles",
                 ev_seen[wtip_pkg::EV_TOO_LONG], ev_seen[wtip_pkg::EV_END], fails, cycles);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: whitespace_tokenizer_int_parse.f
design/wtip_pkg.sv
design/wtip_in_if.sv
design/wtip_out_if.sv
design/whitespace_tokenizer_int_parse.sv
tb/tb_whitespace_tokenizer_int_parse.sv
